/* sv/istc_pkg.sv */
// Shared types, sizes and helpers for the identifier set table.
// Used by istc_cell, istc_pick and id_set_table_with_cursor_unit; no dependencies.
package istc_pkg;

  // Table size and derived widths.
  localparam int TABLE_SLOTS = 64;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CUR_W       = $clog2(TABLE_SLOTS + 1);
  localparam int ID_W        = 32;
  localparam int OUT_SLOT_W  = 6;
  localparam int OP_W        = 3;

  // Cells are grouped for the two-level priority pick.
  localparam int GRP_N = 8;
  localparam int GRP_W = $clog2(GRP_N);
  localparam int NGRP  = (TABLE_SLOTS + GRP_N - 1) / GRP_N;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_FIRST  = 3'd3,
    OP_NEXT   = 3'd4
  } op_e;

  // Command broadcast to every cell.
  typedef struct packed {
    logic              cmp_en;
    logic [ID_W-1:0]   key;
    logic [CUR_W-1:0]  scan_lo;
    logic              scan_none;
    logic              wr_en;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   wr_data;
  } cell_cmd_t;

  // Per-cell search flags: key match, empty slot, occupied at or above the scan start.
  typedef struct packed {
    logic key;
    logic emp;
    logic scan;
  } flag_t;

  // Result of the priority pick over the whole table.
  typedef struct packed {
    logic              key_hit;
    logic [SLOT_W-1:0] key_slot;
    logic              emp_hit;
    logic [SLOT_W-1:0] emp_slot;
    logic              scan_hit;
    logic [SLOT_W-1:0] scan_slot;
  } pick_t;

  // Reduce a slot number to the low bits shown on the result port.
  function automatic logic [OUT_SLOT_W-1:0] slot_to_out(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+OUT_SLOT_W-1:0] t;
    t = {{OUT_SLOT_W{1'b0}}, s};
    return t[OUT_SLOT_W-1:0];
  endfunction

endpackage

/* sv/istc_cell.sv */
// One slot of the identifier table with its local compare flags and neighbor chains.
// Depends on istc_pkg.
module istc_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [istc_pkg::SLOT_W-1:0] idx_i,
  input  istc_pkg::cell_cmd_t       cmd_i,
  input  istc_pkg::flag_t           up_i,
  input  istc_pkg::flag_t           dn_i,
  output istc_pkg::flag_t           carry_o,
  output istc_pkg::flag_t           sel_o,
  output logic [istc_pkg::ID_W-1:0] rd_o
);

  logic [istc_pkg::ID_W-1:0] id_q;
  istc_pkg::flag_t           flag_q, flag_d;
  logic                      addr_hit;
  logic [istc_pkg::CUR_W-1:0] idx_ext;

  assign addr_hit = (cmd_i.slot == idx_i);
  assign idx_ext  = istc_pkg::CUR_W'(idx_i);

  // Local compares against the broadcast key and scan start.
  always_comb begin
    flag_d.key  = (id_q == cmd_i.key);
    flag_d.emp  = (id_q == '0);
    flag_d.scan = (id_q != '0) && !cmd_i.scan_none && (idx_ext >= cmd_i.scan_lo);
  end

  // Stored identifier; reset empties the slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q <= '0;
    end else if (cmd_i.wr_en && addr_hit) begin
      id_q <= cmd_i.wr_data;
    end
  end

  // Flags are captured when a transaction is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
    end else if (cmd_i.cmp_en) begin
      flag_q <= flag_d;
    end
  end

  // Match and empty searches favor the highest slot, so their carries run downward;
  // the scan favors the lowest slot, so its carry runs upward.
  always_comb begin
    carry_o.key  = flag_q.key  | up_i.key;
    carry_o.emp  = flag_q.emp  | up_i.emp;
    carry_o.scan = flag_q.scan | dn_i.scan;
    sel_o.key    = flag_q.key  & ~up_i.key;
    sel_o.emp    = flag_q.emp  & ~up_i.emp;
    sel_o.scan   = flag_q.scan & ~dn_i.scan;
  end

  // Read port: only the addressed cell drives nonzero data.
  assign rd_o = addr_hit ? id_q : '0;

endmodule

/* sv/istc_pick.sv */
// Two-level priority pick: per-group encode of the cell selections, then a pick over groups.
// Depends on istc_pkg.
module istc_pick (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  istc_pkg::flag_t        sel_i [istc_pkg::TABLE_SLOTS],
  output istc_pkg::pick_t        res_o
);

  typedef struct packed {
    logic                      kv;
    logic [istc_pkg::GRP_W-1:0] kl;
    logic                      ev;
    logic [istc_pkg::GRP_W-1:0] el;
    logic                      sv;
    logic [istc_pkg::GRP_W-1:0] sl;
  } grp_t;

  grp_t grp_d [istc_pkg::NGRP];
  grp_t grp_q [istc_pkg::NGRP];

  // Within a group at most one cell is selected per search, so OR encodes it.
  always_comb begin
    for (int g = 0; g < istc_pkg::NGRP; g++) begin
      grp_d[g] = '0;
      for (int l = 0; l < istc_pkg::GRP_N; l++) begin
        if (g * istc_pkg::GRP_N + l < istc_pkg::TABLE_SLOTS) begin
          if (sel_i[g * istc_pkg::GRP_N + l].key) begin
            grp_d[g].kv = 1'b1;
            grp_d[g].kl = grp_d[g].kl | istc_pkg::GRP_W'(l);
          end
          if (sel_i[g * istc_pkg::GRP_N + l].emp) begin
            grp_d[g].ev = 1'b1;
            grp_d[g].el = grp_d[g].el | istc_pkg::GRP_W'(l);
          end
          if (sel_i[g * istc_pkg::GRP_N + l].scan) begin
            grp_d[g].sv = 1'b1;
            grp_d[g].sl = grp_d[g].sl | istc_pkg::GRP_W'(l);
          end
        end
      end
    end
  end

  // Group results register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < istc_pkg::NGRP; g++) begin
        grp_q[g] <= '0;
      end
    end else if (load_i) begin
      for (int g = 0; g < istc_pkg::NGRP; g++) begin
        grp_q[g] <= grp_d[g];
      end
    end
  end

  // Highest group wins for match and empty, lowest group wins for the scan.
  always_comb begin
    res_o = '0;
    for (int g = 0; g < istc_pkg::NGRP; g++) begin
      if (grp_q[g].kv) begin
        res_o.key_hit  = 1'b1;
        res_o.key_slot = istc_pkg::SLOT_W'(g * istc_pkg::GRP_N + int'(grp_q[g].kl));
      end
      if (grp_q[g].ev) begin
        res_o.emp_hit  = 1'b1;
        res_o.emp_slot = istc_pkg::SLOT_W'(g * istc_pkg::GRP_N + int'(grp_q[g].el));
      end
    end
    for (int g = istc_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp_q[g].sv) begin
        res_o.scan_hit  = 1'b1;
        res_o.scan_slot = istc_pkg::SLOT_W'(g * istc_pkg::GRP_N + int'(grp_q[g].sl));
      end
    end
  end

endmodule

/* sv/id_set_table_with_cursor_unit.sv */
// Top level of the identifier set table with a walk cursor.
// Depends on istc_pkg, istc_cell and istc_pick.

// The table is a row of cells, one per slot, each holding a 32-bit identifier
// (zero means empty) and comparing it against the broadcast key in the cycle a
// transaction is accepted. Selection chains between neighboring cells inside
// groups of eight, then a pick over the groups, find the highest matching slot,
// the highest empty slot and the lowest occupied slot at or above the walk start.
// One transaction is in flight at a time. The compare is captured at the accepting
// edge, and the result then passes the group encode, group pick and table update
// steps before it is loaded into the output register. The next transaction is
// accepted in the cycle after the update. A waiting result holds the update step
// until the output frees up.
// The table resets empty and the cursor resets invalid.
module id_set_table_with_cursor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] key_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [31:0] id_out_o,
  output logic [5:0]  slot_index_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_GRP   = 2'd1;
  localparam logic [1:0] ST_SEL   = 2'd2;
  localparam logic [1:0] ST_APPLY = 2'd3;

  logic [1:0] state_q, state_d;

  logic                         in_fire;
  logic                         apply_go;
  istc_pkg::op_e                op_q;
  logic [istc_pkg::ID_W-1:0]    key_q;
  logic                         cur_valid_q;
  logic [istc_pkg::CUR_W-1:0]   cur_q;
  logic [istc_pkg::CUR_W-1:0]   scan_lo;
  logic                         scan_none;
  istc_pkg::cell_cmd_t          cmd;
  istc_pkg::flag_t              carry_w [istc_pkg::TABLE_SLOTS];
  istc_pkg::flag_t              up_w    [istc_pkg::TABLE_SLOTS];
  istc_pkg::flag_t              dn_w    [istc_pkg::TABLE_SLOTS];
  istc_pkg::flag_t              sel_w   [istc_pkg::TABLE_SLOTS];
  logic [istc_pkg::ID_W-1:0]    rd_w    [istc_pkg::TABLE_SLOTS];
  logic [istc_pkg::ID_W-1:0]    rd_data;
  istc_pkg::pick_t              pick;

  // Decision registers, filled in the select step.
  logic                         dec_ok_q, dec_ok_d;
  logic [istc_pkg::SLOT_W-1:0]  dec_slot_q, dec_slot_d;
  logic                         dec_wr_q, dec_wr_d;
  logic [istc_pkg::ID_W-1:0]    dec_wdata_q, dec_wdata_d;
  logic                         dec_rd_q, dec_rd_d;
  logic                         dec_cur_wr_q, dec_cur_wr_d;
  logic                         dec_cur_valid_q, dec_cur_valid_d;
  logic [istc_pkg::CUR_W-1:0]   dec_cur_q, dec_cur_d;

  // Output register.
  logic                         out_valid_q;
  logic                         ok_q;
  logic [istc_pkg::ID_W-1:0]    id_q;
  logic [istc_pkg::OUT_SLOT_W-1:0] slot_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign apply_go   = (state_q == ST_APPLY) && (!out_valid_q || out_ready_i);

  // Walk start for first and next; an exhausted first leaves nothing to scan.
  always_comb begin
    scan_lo   = '0;
    scan_none = 1'b0;
    if (istc_pkg::op_e'(operation_i) == istc_pkg::OP_NEXT && cur_valid_q) begin
      if (cur_q == istc_pkg::CUR_W'(istc_pkg::TABLE_SLOTS)) begin
        scan_none = 1'b1;
      end else begin
        scan_lo = cur_q + istc_pkg::CUR_W'(1);
      end
    end
  end

  // Command broadcast to the cells.
  always_comb begin
    cmd.cmp_en    = in_fire;
    cmd.key       = key_id_i;
    cmd.scan_lo   = scan_lo;
    cmd.scan_none = scan_none;
    cmd.wr_en     = apply_go && dec_wr_q;
    cmd.slot      = dec_slot_q;
    cmd.wr_data   = dec_wdata_q;
  end

  // Row of cells with neighbor chains broken at group boundaries.
  for (genvar s = 0; s < istc_pkg::TABLE_SLOTS; s++) begin : g_cell
    if ((s % istc_pkg::GRP_N) == istc_pkg::GRP_N - 1 || s == istc_pkg::TABLE_SLOTS - 1)
    begin : g_top
      assign up_w[s] = '0;
    end else begin : g_mid_up
      assign up_w[s] = carry_w[s+1];
    end
    if ((s % istc_pkg::GRP_N) == 0) begin : g_bot
      assign dn_w[s] = '0;
    end else begin : g_mid_dn
      assign dn_w[s] = carry_w[s-1];
    end

    istc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (istc_pkg::SLOT_W'(s)),
      .cmd_i   (cmd),
      .up_i    (up_w[s]),
      .dn_i    (dn_w[s]),
      .carry_o (carry_w[s]),
      .sel_o   (sel_w[s]),
      .rd_o    (rd_w[s])
    );
  end

  // Priority pick over the cell selections.
  istc_pick u_pick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (state_q == ST_GRP),
    .sel_i  (sel_w),
    .res_o  (pick)
  );

  // Read data: only the addressed cell drives nonzero bits.
  always_comb begin
    rd_data = '0;
    for (int s = 0; s < istc_pkg::TABLE_SLOTS; s++) begin
      rd_data = rd_data | rd_w[s];
    end
  end

  // Operation decision from the pick results.
  always_comb begin
    dec_ok_d        = 1'b0;
    dec_slot_d      = '0;
    dec_wr_d        = 1'b0;
    dec_wdata_d     = '0;
    dec_rd_d        = 1'b0;
    dec_cur_wr_d    = 1'b0;
    dec_cur_valid_d = 1'b0;
    dec_cur_d       = '0;
    unique case (op_q)
      istc_pkg::OP_INSERT: begin
        if (key_q != '0) begin
          if (pick.key_hit) begin
            dec_ok_d   = 1'b1;
            dec_slot_d = pick.key_slot;
          end else if (pick.emp_hit) begin
            dec_ok_d    = 1'b1;
            dec_slot_d  = pick.emp_slot;
            dec_wr_d    = 1'b1;
            dec_wdata_d = key_q;
          end
          dec_cur_wr_d    = dec_ok_d;
          dec_cur_valid_d = 1'b1;
          dec_cur_d       = istc_pkg::CUR_W'(dec_slot_d);
        end
      end
      istc_pkg::OP_DELETE: begin
        if (key_q != '0 && pick.key_hit) begin
          dec_ok_d    = 1'b1;
          dec_slot_d  = pick.key_slot;
          dec_wr_d    = 1'b1;
          dec_wdata_d = '0;
        end
      end
      istc_pkg::OP_LOOKUP: begin
        if (key_q != '0 && pick.key_hit) begin
          dec_ok_d   = 1'b1;
          dec_slot_d = pick.key_slot;
        end
      end
      istc_pkg::OP_FIRST: begin
        dec_cur_wr_d    = 1'b1;
        dec_cur_valid_d = 1'b1;
        if (pick.scan_hit) begin
          dec_ok_d   = 1'b1;
          dec_slot_d = pick.scan_slot;
          dec_rd_d   = 1'b1;
          dec_cur_d  = istc_pkg::CUR_W'(pick.scan_slot);
        end else begin
          dec_cur_d = istc_pkg::CUR_W'(istc_pkg::TABLE_SLOTS);
        end
      end
      istc_pkg::OP_NEXT: begin
        dec_cur_wr_d = 1'b1;
        if (pick.scan_hit) begin
          dec_ok_d        = 1'b1;
          dec_slot_d      = pick.scan_slot;
          dec_rd_d        = 1'b1;
          dec_cur_valid_d = 1'b1;
          dec_cur_d       = istc_pkg::CUR_W'(pick.scan_slot);
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_GRP;
      ST_GRP:   state_d = ST_SEL;
      ST_SEL:   state_d = ST_APPLY;
      ST_APPLY: if (apply_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Captured transaction.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= istc_pkg::op_e'(operation_i);
      key_q <= key_id_i;
    end
  end

  // Decision registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_ok_q        <= 1'b0;
      dec_wr_q        <= 1'b0;
      dec_rd_q        <= 1'b0;
      dec_cur_wr_q    <= 1'b0;
      dec_cur_valid_q <= 1'b0;
    end else if (state_q == ST_SEL) begin
      dec_ok_q        <= dec_ok_d;
      dec_wr_q        <= dec_wr_d;
      dec_rd_q        <= dec_rd_d;
      dec_cur_wr_q    <= dec_cur_wr_d;
      dec_cur_valid_q <= dec_cur_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEL) begin
      dec_slot_q  <= dec_slot_d;
      dec_wdata_q <= dec_wdata_d;
      dec_cur_q   <= dec_cur_d;
    end
  end

  // Walk cursor; reset leaves it invalid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cur_q       <= '0;
    end else if (apply_go && dec_cur_wr_q) begin
      cur_valid_q <= dec_cur_valid_q;
      cur_q       <= dec_cur_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (apply_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_go) begin
      ok_q   <= dec_ok_q;
      id_q   <= dec_rd_q ? rd_data : '0;
      slot_q <= dec_ok_q ? istc_pkg::slot_to_out(dec_slot_q) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign id_out_o     = id_q;
  assign slot_index_o = slot_q;

endmodule
